// ===== src/rbd_pkg.sv =====
// Package: deque types, command codes, controller states and pointer helpers.
`timescale 1ns / 1ps

package rbd_pkg;

  localparam int DEPTH     = 1024;
  localparam int PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int OUT_CNT_W = 11;
  localparam int DATA_W    = 32;
  localparam int CMD_W     = 3;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PEEK       = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FETCH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] push_value;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic                     pop_hit;
    logic                     push_refused;
    logic [OUT_CNT_W-1:0]     element_count;
    logic                     is_empty;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic fetch;
    logic done;
  } ctrl_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == '0) begin
      r = PTR_W'(DEPTH - 1);
    end else begin
      r = p - PTR_W'(1);
    end
    return r;
  endfunction

endpackage

// ===== src/ring_buffer_deque_core.sv =====
// Top level: double-ended queue in a circular store, controller plus datapath.
//
//   channel  ports                     handshake
//   input    start, busy, in_word      taken when start and not busy
//   result   out_valid, out_word       one-cycle strobe, always taken
//
// Each command passes through execute (pointer update, store write,
// popped-entry read), fetch (front and back reads) and result. The single
// store read/write sequence sets these steps. A new command is taken in the
// result cycle, not before. Reset clears the controller state, pointers and
// count only; the store needs no clearing. The receiver cannot stall.
`timescale 1ns / 1ps

module ring_buffer_deque_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  rbd_pkg::in_word_t   in_word,
  output logic                out_valid,
  output rbd_pkg::out_word_t  out_word
);

  rbd_pkg::ctrl_t ctrl;

  rbd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  rbd_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .in_word  (in_word),
    .out_word (out_word)
  );

  assign out_valid = ctrl.done;

`ifndef SYNTHESIS
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.is_empty == (out_word.element_count == '0)))
    else $error("empty flag disagrees with count");
`endif

endmodule

// ===== src/rbd_ctrl.sv =====
// Controller: sequences one command through execute, fetch and result cycles.
`timescale 1ns / 1ps

module rbd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output rbd_pkg::ctrl_t ctrl
);

  rbd_pkg::state_t state_r;
  rbd_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rbd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    busy       = 1'b0;
    ctrl       = '0;
    unique case (state_r)
      rbd_pkg::ST_IDLE: begin
        if (start) begin
          ctrl.load = 1'b1;
          state_nxt = rbd_pkg::ST_EXEC;
        end
      end
      rbd_pkg::ST_EXEC: begin
        busy      = 1'b1;
        ctrl.exec = 1'b1;
        state_nxt = rbd_pkg::ST_FETCH;
      end
      rbd_pkg::ST_FETCH: begin
        busy       = 1'b1;
        ctrl.fetch = 1'b1;
        state_nxt  = rbd_pkg::ST_DONE;
      end
      rbd_pkg::ST_DONE: begin
        ctrl.done = 1'b1;
        if (start) begin
          ctrl.load = 1'b1;
          state_nxt = rbd_pkg::ST_EXEC;
        end else begin
          state_nxt = rbd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rbd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/rbd_datapath.sv =====
// Datapath: element store, pointers, count and result registers.
`timescale 1ns / 1ps

module rbd_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  rbd_pkg::ctrl_t    ctrl,
  input  rbd_pkg::in_word_t in_word,
  output rbd_pkg::out_word_t out_word
);

  localparam int PW = rbd_pkg::PTR_W;
  localparam int CW = rbd_pkg::CNT_W;
  localparam int DW = rbd_pkg::DATA_W;

  logic [DW-1:0] mem [rbd_pkg::DEPTH];

  logic [rbd_pkg::CMD_W-1:0] cmd_r;
  logic [DW-1:0]             val_r;
  logic [PW-1:0]             front_r, front_nxt;
  logic [PW-1:0]             back_r, back_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic                      hit_r, hit_nxt;
  logic                      refused_r, refused_nxt;
  logic [DW-1:0]             popped_r;
  logic [DW-1:0]             rd_a_r, rd_b_r;

  logic          full, empty;
  logic          we;
  logic [PW-1:0] wr_addr;
  logic [PW-1:0] pop_addr;
  logic [PW-1:0] rd_addr_a, rd_addr_b;

  assign full  = (count_r == CW'(rbd_pkg::DEPTH));
  assign empty = (count_r == '0);

  always_comb begin
    front_nxt   = front_r;
    back_nxt    = back_r;
    count_nxt   = count_r;
    hit_nxt     = 1'b0;
    refused_nxt = 1'b0;
    we          = 1'b0;
    wr_addr     = back_r;
    pop_addr    = front_r;
    case (cmd_r)
      rbd_pkg::CMD_PUSH_FRONT: begin
        if (full) begin
          refused_nxt = 1'b1;
        end else begin
          front_nxt = rbd_pkg::ptr_dec(front_r);
          wr_addr   = front_nxt;
          we        = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
      rbd_pkg::CMD_PUSH_BACK: begin
        if (full) begin
          refused_nxt = 1'b1;
        end else begin
          wr_addr   = back_r;
          back_nxt  = rbd_pkg::ptr_inc(back_r);
          we        = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
      rbd_pkg::CMD_POP_FRONT: begin
        if (!empty) begin
          pop_addr  = front_r;
          front_nxt = rbd_pkg::ptr_inc(front_r);
          count_nxt = count_r - CW'(1);
          hit_nxt   = 1'b1;
        end
      end
      rbd_pkg::CMD_POP_BACK: begin
        if (!empty) begin
          back_nxt  = rbd_pkg::ptr_dec(back_r);
          pop_addr  = back_nxt;
          count_nxt = count_r - CW'(1);
          hit_nxt   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign rd_addr_a = ctrl.exec ? pop_addr : front_r;
  assign rd_addr_b = rbd_pkg::ptr_dec(back_r);

  always_ff @(posedge clk) begin
    if (ctrl.exec && we) begin
      mem[wr_addr] <= val_r;
    end
    rd_a_r <= mem[rd_addr_a];
    rd_b_r <= mem[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      back_r  <= '0;
      count_r <= '0;
    end else if (ctrl.exec) begin
      front_r <= front_nxt;
      back_r  <= back_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r <= in_word.cmd;
      val_r <= in_word.push_value;
    end
    if (ctrl.exec) begin
      hit_r     <= hit_nxt;
      refused_r <= refused_nxt;
    end
    if (ctrl.fetch) begin
      popped_r <= hit_r ? rd_a_r : '0;
    end
  end

  always_comb begin
    out_word.popped_value  = popped_r;
    out_word.pop_hit       = hit_r;
    out_word.push_refused  = refused_r;
    out_word.element_count = rbd_pkg::OUT_CNT_W'(count_r);
    out_word.is_empty      = empty;
    out_word.front_value   = empty ? '0 : rd_a_r;
    out_word.back_value    = empty ? '0 : rd_b_r;
  end

endmodule
